[src/q8b_pkg.sv]
// shared types, constants and helper functions of the q8_1 block quantizer
// no dependencies; used by the front, queue, back and top-level files of the block
package q8b_pkg;

	localparam int BLOCK_LEN = 32;
	localparam int LANE_W    = 5;
	localparam int ADDR_W    = 6;
	localparam int FILL_W    = 6;
	localparam int EXP_W     = 8;

	// significands with hidden one at bit 23
	localparam logic [23:0] SIG_ONE = 24'h800000;
	localparam logic [15:0] HALF_MAX_MAG = 16'h7BFF;
	// 2^20 / 127 rounded up, exact floor quotient for 11-bit numerators
	localparam logic [13:0] RECIP_127 = 14'd8257;

	typedef logic signed [EXP_W-1:0] exp_t;

	// normalized half magnitude: sig has its leading one at bit 10
	typedef struct packed {
		logic [10:0] sig;
		exp_t        ex;
	} hnorm_t;

	typedef struct packed {
		logic [14:0]       peak;
		logic [FILL_W-1:0] fill;
	} blk_desc_t;

	// front to queue
	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [15:0]       wr_data;
		logic              push;
		blk_desc_t         desc;
	} q_wr_t;

	// queue to front
	typedef struct packed {
		logic full;
		logic slot;
	} q_tail_t;

	// queue to back
	typedef struct packed {
		logic      avail;
		logic      slot;
		blk_desc_t desc;
	} q_head_t;

	// back to queue
	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              pop;
	} q_rd_t;

	// infinity becomes the largest finite half, nan becomes zero
	function automatic logic [15:0] sanitize(input logic [15:0] h);
		logic [15:0] r;
		r = h;
		if (h[14:10] == 5'h1F) begin
			if (h[9:0] != 10'd0) begin
				r = 16'h0000;
			end else begin
				r = {h[15], HALF_MAX_MAG[14:0]};
			end
		end
		return r;
	endfunction

	// half magnitude to normalized significand and unbiased exponent
	function automatic hnorm_t half_norm(input logic [14:0] mag);
		hnorm_t     r;
		logic [4:0] e;
		logic [9:0] m;
		logic [3:0] p;
		e = mag[14:10];
		m = mag[9:0];
		p = '0;
		r.sig = '0;
		r.ex = '0;
		if (e != 5'd0) begin
			r.sig = {1'b1, m};
			r.ex = exp_t'({3'b000, e}) - exp_t'(15);
		end else if (m != 10'd0) begin
			for (int i = 0; i < 10; i++) begin
				if (m[i]) p = 4'(i);
			end
			r.sig = 11'({1'b0, m} << (4'd10 - p));
			r.ex = exp_t'({4'b0000, p}) - exp_t'(24);
		end
		return r;
	endfunction

endpackage

[src/q8b_in_if.sv]
// input channel: one half value per request
// depends on nothing
interface q8b_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] half_value;

	modport source (output valid, output half_value, input ready);
	modport sink (input valid, input half_value, output ready);
endinterface

[src/q8b_out_if.sv]
// output channel: one quantized lane per request
// depends on nothing
interface q8b_out_if;
	logic              valid;
	logic              ready;
	logic signed [7:0] quant_value;
	logic [4:0]        lane_index;
	logic [15:0]       block_scale;
	logic signed [12:0] quant_sum;
	logic              block_last;

	modport source (output valid, output quant_value, output lane_index,
		output block_scale, output quant_sum, output block_last, input ready);
	modport sink (input valid, input quant_value, input lane_index,
		input block_scale, input quant_sum, input block_last, output ready);
endinterface

[src/q8b_front.sv]
// front end: takes requests, tracks lanes, row position and block peak
// depends on q8b_pkg and q8b_in_if
module q8b_front #(
	parameter int MAX_ROW_LEN = 16384
) (
	input  logic             clk,
	input  logic             arst_n,
	q8b_in_if.sink           din,
	input  logic             cfg_we,
	input  logic [14:0]      cfg_wdata,
	input  q8b_pkg::q_tail_t tail,
	output q8b_pkg::q_wr_t   wr
);

	localparam int CW = $clog2(MAX_ROW_LEN + 1);
	localparam int WW = (CW > 15) ? CW : 15;
	localparam logic [WW-1:0] MAX_L = WW'(MAX_ROW_LEN);

	logic [14:0]                  row_length_q;
	logic [14:0]                  peak_q;
	logic [q8b_pkg::LANE_W-1:0]   lane_q;
	logic [CW-1:0]                col_q;
	logic [15:0]                  h;
	logic [14:0]                  peak_nxt;
	logic [WW-1:0]                eff_len;
	logic [WW-1:0]                col_nxt;
	logic                         row_end;
	logic                         blk_done;
	logic                         take;

	assign din.ready = !tail.full;
	assign take = din.valid && din.ready;

	// classify the incoming value
	always_comb begin
		h = q8b_pkg::sanitize(din.half_value);
		peak_nxt = (h[14:0] > peak_q) ? h[14:0] : peak_q;
		if (row_length_q == 15'd0) begin
			eff_len = WW'(1);
		end else if (WW'(row_length_q) > MAX_L) begin
			eff_len = MAX_L;
		end else begin
			eff_len = WW'(row_length_q);
		end
		col_nxt = WW'(col_q) + WW'(1);
		row_end = col_nxt >= eff_len;
		blk_done = (lane_q == q8b_pkg::LANE_W'(q8b_pkg::BLOCK_LEN - 1)) || row_end;
	end

	// write into the free queue slot
	always_comb begin
		wr.wr_en = take;
		wr.wr_addr = {tail.slot, lane_q};
		wr.wr_data = h;
		wr.push = take && blk_done;
		wr.desc.peak = peak_nxt;
		wr.desc.fill = q8b_pkg::FILL_W'({1'b0, lane_q}) + q8b_pkg::FILL_W'(1);
	end

	// lane, column and peak tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= 15'd32;
			peak_q <= '0;
			lane_q <= '0;
			col_q <= '0;
		end else begin
			if (cfg_we) begin
				row_length_q <= cfg_wdata;
			end
			if (take) begin
				if (blk_done) begin
					lane_q <= '0;
					peak_q <= '0;
					col_q <= row_end ? '0 : CW'(col_nxt);
				end else begin
					lane_q <= lane_q + q8b_pkg::LANE_W'(1);
					peak_q <= peak_nxt;
					col_q <= CW'(col_nxt);
				end
			end
		end
	end

endmodule

[src/q8b_queue.sv]
// two-slot block queue between front and back: value memory and descriptors
// depends on q8b_pkg
module q8b_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  q8b_pkg::q_wr_t   wr,
	output q8b_pkg::q_tail_t tail,
	input  q8b_pkg::q_rd_t   rd,
	output q8b_pkg::q_head_t head,
	output logic [15:0]      rd_data
);

	logic [15:0]        mem [2*q8b_pkg::BLOCK_LEN];
	q8b_pkg::blk_desc_t desc_q [2];
	logic               wptr_q;
	logic               rptr_q;
	logic [1:0]         cnt_q;

	assign tail.full = (cnt_q == 2'd2);
	assign tail.slot = wptr_q;
	assign head.avail = (cnt_q != 2'd0);
	assign head.slot = rptr_q;
	assign head.desc = desc_q[rptr_q];

	// value memory, registered read
	always_ff @(posedge clk) begin
		if (wr.wr_en) begin
			mem[wr.wr_addr] <= wr.wr_data;
		end
		if (rd.rd_en) begin
			rd_data <= mem[rd.rd_addr];
		end
		if (wr.push) begin
			desc_q[wptr_q] <= wr.desc;
		end
	end

	// slot pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr.push) wptr_q <= !wptr_q;
			if (rd.pop) rptr_q <= !rptr_q;
			unique case ({wr.push, rd.pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[src/q8b_back.sv]
// back end: scale by constant reciprocal, bit-serial fp32 reciprocal, lane quantize, emit
// depends on q8b_pkg and q8b_out_if
module q8b_back (
	input  logic             clk,
	input  logic             arst_n,
	input  q8b_pkg::q_head_t head,
	input  logic [15:0]      rd_data,
	output q8b_pkg::q_rd_t   rd,
	q8b_out_if.source        dout
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_DSCALE, ST_SETUP, ST_DIV, ST_SCALE, ST_QUANT, ST_EMIT
	} state_t;

	state_t                      state_q;
	logic [23:0]                 num_sig_q;
	q8b_pkg::exp_t               num_exp_q;
	logic [23:0]                 dsor_q;
	q8b_pkg::exp_t               dsor_exp_q;
	logic [25:0]                 rem_q;
	logic [24:0]                 qbits_q;
	q8b_pkg::exp_t               qexp_q;
	logic [4:0]                  step_q;
	logic [23:0]                 d_sig_q;
	q8b_pkg::exp_t               d_exp_q;
	logic [23:0]                 id_sig_q;
	q8b_pkg::exp_t               id_exp_q;
	logic [15:0]                 scale_q;
	logic [q8b_pkg::FILL_W-1:0]  fill_q;
	logic [5:0]                  issue_q;
	logic signed [12:0]          sum_q;
	logic [4:0]                  emit_q;
	logic signed [7:0]           qbuf_q [q8b_pkg::BLOCK_LEN];

	// lane pipeline
	logic                        v_s1, v_s2, v_s3;
	logic [4:0]                  lane_s1, lane_s2, lane_s3;
	logic                        pad_s1;
	logic [34:0]                 prod_s2;
	q8b_pkg::exp_t               pexp_s2;
	logic                        zero_s2, neg_s2;
	logic signed [7:0]           q_s3;

	// combinational pieces
	logic [25:0]                 rem_sub;
	logic                        ge;
	logic [24:0]                 rnd_sum;
	logic [23:0]                 rnd_sig;
	q8b_pkg::exp_t               rnd_exp;
	logic                        rnd_up;
	logic [24:0]                 sc_prod;
	logic [4:0]                  sc_a;
	logic [11:0]                 sc_diff;
	logic [6:0]                  sc_r;
	logic [32:0]                 sc_fix;
	logic [23:0]                 sc_sig;
	logic                        sc_g;
	logic                        sc_up;
	logic [24:0]                 sc_sum;
	q8b_pkg::exp_t               sc_exp;
	logic [23:0]                 ds_sig;
	q8b_pkg::exp_t               ds_exp;
	q8b_pkg::hnorm_t             pk_n;
	q8b_pkg::hnorm_t             x_n;
	logic [15:0]                 x_val;
	q8b_pkg::exp_t               he;
	logic [4:0]                  hsh;
	logic [23:0]                 hm, hrem, hhalf;
	logic [15:0]                 half_out;
	logic [23:0]                 psig;
	logic                        pg, pst, pup;
	logic [24:0]                 psum;
	logic [23:0]                 asig;
	q8b_pkg::exp_t               aexp;
	q8b_pkg::exp_t               ash;
	logic [8:0]                  t;
	logic [8:0]                  qr;
	logic [6:0]                  qmag;

	// divider step and final rounding
	always_comb begin
		ge = rem_q >= {2'b00, dsor_q};
		rem_sub = ge ? (rem_q - {2'b00, dsor_q}) : rem_q;
		rnd_up = qbits_q[0] && ((rem_q != 26'd0) || qbits_q[1]);
		rnd_sum = {1'b0, qbits_q[24:1]} + {24'd0, rnd_up};
		if (rnd_sum[24]) begin
			rnd_sig = q8b_pkg::SIG_ONE;
			rnd_exp = qexp_q + q8b_pkg::exp_t'(1);
		end else begin
			rnd_sig = rnd_sum[23:0];
			rnd_exp = qexp_q;
		end
		pk_n = q8b_pkg::half_norm(head.desc.peak);
	end

	// peak / 127: integer quotient by reciprocal multiply, the fraction r/127
	// repeats the 7-bit remainder forever, so any nonzero remainder is sticky
	always_comb begin
		sc_prod = 25'(num_sig_q[23:13]) * 25'(q8b_pkg::RECIP_127);
		sc_a = sc_prod[24:20];
		sc_diff = {1'b0, num_sig_q[23:13]} - 12'(sc_a) * 12'd127;
		sc_r = sc_diff[6:0];
		sc_fix = {sc_a, sc_r, sc_r, sc_r, sc_r};
		if (sc_a[4]) begin
			sc_sig = sc_fix[32:9];
			sc_g = sc_fix[8];
			sc_exp = num_exp_q - q8b_pkg::exp_t'(6);
		end else begin
			sc_sig = sc_fix[31:8];
			sc_g = sc_fix[7];
			sc_exp = num_exp_q - q8b_pkg::exp_t'(7);
		end
		sc_up = sc_g && ((sc_r != 7'd0) || sc_sig[0]);
		sc_sum = {1'b0, sc_sig} + {24'd0, sc_up};
		if (sc_sum[24]) begin
			ds_sig = q8b_pkg::SIG_ONE;
			ds_exp = sc_exp + q8b_pkg::exp_t'(1);
		end else begin
			ds_sig = sc_sum[23:0];
			ds_exp = sc_exp;
		end
	end

	// fp32 scale to half, nearest even
	always_comb begin
		he = d_exp_q + q8b_pkg::exp_t'(15);
		hsh = 5'(q8b_pkg::exp_t'(14) - he);
		hm = d_sig_q >> hsh;
		hrem = d_sig_q & ((24'd1 << hsh) - 24'd1);
		hhalf = 24'd1 << (hsh - 5'd1);
		half_out = 16'h0000;
		if (he >= q8b_pkg::exp_t'(1)) begin
			half_out = {1'b0, he[4:0], d_sig_q[22:13]};
			if ((d_sig_q[12:0] > 13'h1000) ||
			    ((d_sig_q[12:0] == 13'h1000) && half_out[0])) begin
				half_out = half_out + 16'd1;
			end
		end else if (he >= q8b_pkg::exp_t'(-10)) begin
			half_out = 16'(hm);
			if ((hrem > hhalf) || ((hrem == hhalf) && hm[0])) begin
				half_out = half_out + 16'd1;
			end
		end
	end

	// lane product normalize, round to fp32, then round half away to integer
	always_comb begin
		if (prod_s2[34]) begin
			psig = prod_s2[34:11];
			pg = prod_s2[10];
			pst = |prod_s2[9:0];
			aexp = pexp_s2 + q8b_pkg::exp_t'(1);
		end else begin
			psig = prod_s2[33:10];
			pg = prod_s2[9];
			pst = |prod_s2[8:0];
			aexp = pexp_s2;
		end
		pup = pg && (pst || psig[0]);
		psum = {1'b0, psig} + {24'd0, pup};
		if (psum[24]) begin
			asig = q8b_pkg::SIG_ONE;
			aexp = aexp + q8b_pkg::exp_t'(1);
		end else begin
			asig = psum[23:0];
		end
		ash = q8b_pkg::exp_t'(22) - aexp;
		t = 9'(asig >> ash[4:0]);
		qr = (t + 9'd1) >> 1;
		if (zero_s2 || (aexp <= q8b_pkg::exp_t'(-2))) begin
			qmag = 7'd0;
		end else if ((aexp >= q8b_pkg::exp_t'(7)) || (qr > 9'd127)) begin
			qmag = 7'd127;
		end else begin
			qmag = qr[6:0];
		end
	end

	// memory reads and queue release
	always_comb begin
		rd.rd_en = (state_q == ST_QUANT) && !issue_q[5];
		rd.rd_addr = {head.slot, issue_q[4:0]};
		rd.pop = (state_q == ST_QUANT) && v_s3 && (lane_s3 == 5'd31);
		x_val = pad_s1 ? 16'h0000 : rd_data;
		x_n = q8b_pkg::half_norm(x_val[14:0]);
	end

	// result channel
	assign dout.valid = (state_q == ST_EMIT);
	assign dout.quant_value = qbuf_q[emit_q];
	assign dout.lane_index = emit_q;
	assign dout.block_scale = scale_q;
	assign dout.quant_sum = sum_q;
	assign dout.block_last = (emit_q == 5'd31);

	// lane pipeline registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= rd.rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		lane_s1 <= issue_q[4:0];
		pad_s1 <= {1'b0, issue_q[4:0]} >= fill_q;
		lane_s2 <= lane_s1;
		prod_s2 <= 35'(x_n.sig) * 35'(id_sig_q);
		pexp_s2 <= x_n.ex + id_exp_q;
		zero_s2 <= (x_val[14:0] == 15'd0);
		neg_s2 <= x_val[15];
		lane_s3 <= lane_s2;
		q_s3 <= neg_s2 ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
		if (v_s3) begin
			qbuf_q[lane_s3] <= q_s3;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			num_sig_q <= '0;
			num_exp_q <= '0;
			dsor_q <= '0;
			dsor_exp_q <= '0;
			rem_q <= '0;
			qbits_q <= '0;
			qexp_q <= '0;
			step_q <= '0;
			d_sig_q <= '0;
			d_exp_q <= '0;
			id_sig_q <= '0;
			id_exp_q <= '0;
			scale_q <= '0;
			fill_q <= '0;
			issue_q <= '0;
			sum_q <= '0;
			emit_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					sum_q <= '0;
					issue_q <= '0;
					if (head.avail) begin
						fill_q <= head.desc.fill;
						if (head.desc.peak == 15'd0) begin
							scale_q <= 16'h0000;
							id_sig_q <= '0;
							id_exp_q <= '0;
							state_q <= ST_QUANT;
						end else begin
							num_sig_q <= {pk_n.sig, 13'd0};
							num_exp_q <= pk_n.ex;
							state_q <= ST_DSCALE;
						end
					end
				end
				ST_DSCALE: begin
					d_sig_q <= ds_sig;
					d_exp_q <= ds_exp;
					num_sig_q <= q8b_pkg::SIG_ONE;
					num_exp_q <= '0;
					dsor_q <= ds_sig;
					dsor_exp_q <= ds_exp;
					state_q <= ST_SETUP;
				end
				ST_SETUP: begin
					step_q <= '0;
					qbits_q <= '0;
					if (num_sig_q >= dsor_q) begin
						rem_q <= {2'b00, num_sig_q};
						qexp_q <= num_exp_q - dsor_exp_q;
					end else begin
						rem_q <= {1'b0, num_sig_q, 1'b0};
						qexp_q <= num_exp_q - dsor_exp_q - q8b_pkg::exp_t'(1);
					end
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (step_q != 5'd25) begin
						qbits_q <= {qbits_q[23:0], ge};
						rem_q <= {rem_sub[24:0], 1'b0};
						step_q <= step_q + 5'd1;
					end else begin
						id_sig_q <= rnd_sig;
						id_exp_q <= rnd_exp;
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					scale_q <= half_out;
					state_q <= ST_QUANT;
				end
				ST_QUANT: begin
					if (rd.rd_en) begin
						issue_q <= issue_q + 6'd1;
					end
					if (v_s3) begin
						sum_q <= sum_q + 13'(q_s3);
					end
					if (rd.pop) begin
						emit_q <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (dout.ready) begin
						emit_q <= emit_q + 5'd1;
						if (emit_q == 5'd31) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[src/q8_1_block_quantizer.sv]
// q8_1 block quantizer top level: front end, two-slot block queue, back end
// input: one value per cycle while a queue slot is free; a block leaves the queue after the
// back-end work (scale by reciprocal multiply and bit-serial reciprocal, skipped for a zero
// peak, then the lane pass), then its 32 results go out one per cycle while dout.ready is high
// the back end takes the next block only after all results are out, so output stalls delay it
// reset clears all control state; row_length resets to 32, no clearing pass
module q8_1_block_quantizer #(
	parameter int MAX_ROW_LEN = 16384
) (
	input  logic        clk,
	input  logic        arst_n,
	q8b_in_if.sink      din,
	q8b_out_if.source   dout,
	input  logic        cfg_we,
	input  logic [14:0] cfg_wdata
);

	q8b_pkg::q_wr_t   wr;
	q8b_pkg::q_tail_t tail;
	q8b_pkg::q_rd_t   rd;
	q8b_pkg::q_head_t head;
	logic [15:0]      rd_data;

	// request intake and block gathering
	q8b_front #(
		.MAX_ROW_LEN(MAX_ROW_LEN)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.din(din),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.tail(tail),
		.wr(wr)
	);

	// block queue
	q8b_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr(wr),
		.tail(tail),
		.rd(rd),
		.head(head),
		.rd_data(rd_data)
	);

	// scale and quantize
	q8b_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.rd_data(rd_data),
		.rd(rd),
		.dout(dout)
	);

endmodule
